>>> src/ctilt_pkg.sv
package ctilt_pkg;

    // Fixed-point format
    localparam int ANGLE_FRAC_BITS   = 16;
    localparam int TAB_FRAC          = 24;
    localparam int CORDIC_ITERATIONS = 18;
    localparam int ROUND_SHIFT       = TAB_FRAC - ANGLE_FRAC_BITS;

    // Port widths
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 112;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_STEP_SCALE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT     = 8'd1;

    localparam logic [15:0] GYRO_STEP_SCALE_RST = 16'd5117;
    localparam logic [16:0] GYRO_WEIGHT_RST     = 17'd64225;
    localparam logic [16:0] WEIGHT_ONE          = 17'd65536;

    // Angle limits
    localparam logic signed [47:0] LIM_ROLL   = 48'sd180 <<< ANGLE_FRAC_BITS;
    localparam logic signed [47:0] LIM_PITCH  = 48'sd90 <<< ANGLE_FRAC_BITS;
    localparam logic signed [47:0] LIM_FILTER = 48'sd1024 <<< ANGLE_FRAC_BITS;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd90 <<< TAB_FRAC;

    // Vector moving through the CORDIC chain
    typedef struct packed {
        logic              tag;   // 0 roll, 1 pitch
        logic              zero;  // null vector, angle forced to 0
        logic signed [43:0] x;
        logic signed [43:0] y;
        logic signed [33:0] z;
    } cord_t;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic signed [33:0] atan_tab(input logic [4:0] idx);
        logic signed [33:0] r;
        case (idx)
            5'd0:  r = 34'sd754974720;
            5'd1:  r = 34'sd445687602;
            5'd2:  r = 34'sd235489088;
            5'd3:  r = 34'sd119537938;
            5'd4:  r = 34'sd60000934;
            5'd5:  r = 34'sd30029717;
            5'd6:  r = 34'sd15018523;
            5'd7:  r = 34'sd7509720;
            5'd8:  r = 34'sd3754917;
            5'd9:  r = 34'sd1877466;
            5'd10: r = 34'sd938734;
            5'd11: r = 34'sd469367;
            5'd12: r = 34'sd234684;
            5'd13: r = 34'sd117342;
            5'd14: r = 34'sd58671;
            5'd15: r = 34'sd29335;
            5'd16: r = 34'sd14668;
            5'd17: r = 34'sd7334;
            5'd18: r = 34'sd3667;
            5'd19: r = 34'sd1833;
            5'd20: r = 34'sd917;
            5'd21: r = 34'sd458;
            5'd22: r = 34'sd229;
            5'd23: r = 34'sd115;
            5'd24: r = 34'sd57;
            5'd25: r = 34'sd29;
            5'd26: r = 34'sd14;
            5'd27: r = 34'sd7;
            5'd28: r = 34'sd4;
            5'd29: r = 34'sd2;
            5'd30: r = 34'sd1;
            default: r = 34'sd0;
        endcase
        return r;
    endfunction

    // Quadrant fold so the chain always starts with x >= 0
    function automatic cord_t prerotate(input logic tag, input logic signed [43:0] x,
                                        input logic signed [43:0] y);
        cord_t c;
        c.tag  = tag;
        c.zero = (x == 44'sd0) && (y == 44'sd0);
        c.x    = x;
        c.y    = y;
        c.z    = 34'sd0;
        if (x[43]) begin
            if (!y[43]) begin
                c.x = y;
                c.y = -x;
                c.z = QUARTER_TURN;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -QUARTER_TURN;
            end
        end
        return c;
    endfunction

    // Shift right, rounding half away from zero
    function automatic logic signed [47:0] round_away(input logic signed [47:0] v,
                                                      input int unsigned sh);
        logic [47:0] mag;
        mag = v[47] ? 48'(-v) : 48'(v);
        mag = (mag + (48'd1 << (sh - 1))) >> sh;
        return v[47] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [47:0] clamp(input logic signed [47:0] v,
                                                 input logic signed [47:0] lim);
        logic signed [47:0] r;
        r = v;
        if (v > lim) r = lim;
        if (v < -lim) r = -lim;
        return r;
    endfunction

endpackage

>>> src/complementary_tilt_estimator.sv
// Complementary roll/pitch estimator.
// Input: one IMU sample per s_ transaction (three accel axes, gyro x and y).
// Output: one m_ transaction per sample with filtered roll and pitch plus the
// accelerometer-only angles. Registers are written through cfg_wr_en /
// cfg_index / cfg_wdata; unknown indexes are dropped. The user must write
// them only while the block is idle; the block itself does not enforce this.
// From input to m_tvalid a sample passes squaring and root start, the
// bit-serial square root and the hand-over of the root, the chain of CORDIC
// cells for the pitch vector (one cell per iteration), the capture of the
// chain exit, then four blend stages. The roll vector enters the chain
// during squaring and crosses it while the root is formed. One sample is
// processed at a time; s_tready is high only while no sample is in flight.
// A finished result sits in the output register; the next sample may be
// accepted while it waits, and the blend stage holds if it is still untaken.
// Reset clears the roll and pitch state to zero, restores the register
// defaults and empties the pipeline.
module complementary_tilt_estimator (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y
    input  logic [ctilt_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // roll_deg, pitch_deg, accel_roll_deg, accel_pitch_deg, zero fill
    output logic [ctilt_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [ctilt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctilt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import ctilt_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQUARE, ST_SQSTART, ST_ROOT, ST_FEED, ST_WAIT,
        ST_GYRO, ST_PRED, ST_WEIGH, ST_MIX
    } state_t;

    state_t state_reg;

    logic [15:0] scale_reg;
    logic [16:0] weight_reg;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg;
    logic [31:0]        sumsq_reg;

    logic signed [27:0] roll_angle_reg, pitch_angle_reg;
    logic signed [24:0] acc_r_reg;
    logic signed [23:0] acc_p_reg;

    logic signed [32:0] dprod_r_reg, dprod_p_reg;
    logic signed [28:0] pred_r_reg, pred_p_reg;
    logic signed [46:0] pw_r_reg, pw_p_reg;
    logic signed [42:0] pa_r_reg, pa_p_reg;
    logic [16:0]        w_eff;
    logic [16:0]        w_comp;

    logic               m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic        sq_done;
    logic [23:0] sq_root;

    logic  cell_vld [0:CORDIC_ITERATIONS];
    cord_t cell_dat [0:CORDIC_ITERATIONS];

    logic signed [47:0] exit_ang;
    logic signed [47:0] mix_r, mix_p;
    logic signed [47:0] dl_r, dl_p;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= GYRO_STEP_SCALE_RST;
            weight_reg <= GYRO_WEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GYRO_STEP_SCALE: scale_reg  <= cfg_wdata[15:0];
                REG_GYRO_WEIGHT:     weight_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign w_eff  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_comp = 17'(WEIGHT_ONE - w_eff);

    // Square root of (ay^2 + az^2) * 2^16
    ctilt_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (state_reg == ST_SQSTART),
        .radicand ({sumsq_reg, 16'd0}),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Chain entry: roll vector during squaring, pitch vector after the root
    always_comb begin
        cell_vld[0] = (state_reg == ST_SQUARE) || (state_reg == ST_FEED);
        if (state_reg == ST_FEED) begin
            cell_dat[0] = prerotate(1'b1, $signed({4'd0, sq_root, 16'd0}),
                                    -(44'(ax_reg) <<< 24));
        end else begin
            cell_dat[0] = prerotate(1'b0, 44'(az_reg) <<< 16, 44'(ay_reg) <<< 16);
        end
    end

    for (genvar i = 0; i < CORDIC_ITERATIONS; i++) begin : g_cell
        ctilt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (5'(i)),
            .in_vld    (cell_vld[i]),
            .in_data   (cell_dat[i]),
            .out_vld   (cell_vld[i+1]),
            .out_data  (cell_dat[i+1])
        );
    end

    // Chain exit: round to angle format, clamp per axis
    always_comb begin
        if (cell_dat[CORDIC_ITERATIONS].zero) begin
            exit_ang = 48'sd0;
        end else begin
            exit_ang = round_away(48'(cell_dat[CORDIC_ITERATIONS].z), ROUND_SHIFT);
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_vld[CORDIC_ITERATIONS]) begin
            if (cell_dat[CORDIC_ITERATIONS].tag) begin
                acc_p_reg <= 24'(clamp(exit_ang, LIM_PITCH));
            end else begin
                acc_r_reg <= 25'(clamp(exit_ang, LIM_ROLL));
            end
        end
    end

    // Blend datapath
    always_comb begin
        dl_r  = round_away(48'(dprod_r_reg), ROUND_SHIFT);
        dl_p  = round_away(48'(dprod_p_reg), ROUND_SHIFT);
        mix_r = clamp(round_away(48'(pw_r_reg) + 48'(pa_r_reg), 16), LIM_FILTER);
        mix_p = clamp(round_away(48'(pw_p_reg) + 48'(pa_p_reg), 16), LIM_FILTER);
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                ax_reg <= s_tdata[15:0];
                ay_reg <= s_tdata[31:16];
                az_reg <= s_tdata[47:32];
                gx_reg <= s_tdata[63:48];
                gy_reg <= s_tdata[79:64];
            end
            ST_SQUARE: begin
                sumsq_reg <= 32'(ay_reg * ay_reg) + 32'(az_reg * az_reg);
            end
            ST_GYRO: begin
                dprod_r_reg <= 33'(gx_reg) * $signed({17'd0, scale_reg});
                dprod_p_reg <= 33'(gy_reg) * $signed({17'd0, scale_reg});
            end
            ST_PRED: begin
                pred_r_reg <= 29'(roll_angle_reg) + 29'(dl_r);
                pred_p_reg <= 29'(pitch_angle_reg) + 29'(dl_p);
            end
            ST_WEIGH: begin
                pw_r_reg <= $signed({1'b0, w_eff}) * pred_r_reg;
                pw_p_reg <= $signed({1'b0, w_eff}) * pred_p_reg;
                pa_r_reg <= $signed({1'b0, w_comp}) * acc_r_reg;
                pa_p_reg <= $signed({1'b0, w_comp}) * acc_p_reg;
            end
            default: ;
        endcase
    end

    // Sequencer, filter state and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            roll_angle_reg  <= 28'sd0;
            pitch_angle_reg <= 28'sd0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:    if (s_tvalid) state_reg <= ST_SQUARE;
                ST_SQUARE:  state_reg <= ST_SQSTART;
                ST_SQSTART: state_reg <= ST_ROOT;
                ST_ROOT:    if (sq_done) state_reg <= ST_FEED;
                ST_FEED:    state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (cell_vld[CORDIC_ITERATIONS] && cell_dat[CORDIC_ITERATIONS].tag) begin
                        state_reg <= ST_GYRO;
                    end
                end
                ST_GYRO:    state_reg <= ST_PRED;
                ST_PRED:    state_reg <= ST_WEIGH;
                ST_WEIGH:   state_reg <= ST_MIX;
                ST_MIX: begin
                    if (!m_valid_reg || m_tready) begin
                        roll_angle_reg  <= 28'(mix_r);
                        pitch_angle_reg <= 28'(mix_p);
                        m_data_reg      <= {7'd0, acc_p_reg, acc_r_reg,
                                            28'(mix_p), 28'(mix_r)};
                        m_valid_reg     <= 1'b1;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Chain entry and exit cells are empty whenever a new transaction can be taken
    a_chain_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !cell_vld[CORDIC_ITERATIONS] && !cell_vld[1])
        else $error("CORDIC chain busy while idle");

    // Root completes only while the sequencer waits for it
    a_root_state: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> state_reg == ST_ROOT)
        else $error("square root finished out of sequence");

    // Filtered roll stays within its saturation limit
    a_roll_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[27:0]) <= 28'sd67108864)
                  && ($signed(m_tdata[27:0]) >= -28'sd67108864))
        else $error("roll out of range");

    // A result is written only when the output register is free
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
        else $error("pending result overwritten");

endmodule

>>> src/ctilt_sqrt.sv
module ctilt_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);
    import ctilt_pkg::*;

    logic [47:0] rad_reg;
    logic [25:0] rem_reg;
    logic [23:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [26:0] rem_sh;
    logic [26:0] trial;

    // One result bit per cycle, restoring digit recurrence
    always_comb begin
        rem_sh = {rem_reg[24:0], rad_reg[47:46]};
        trial  = {1'b0, root_reg, 2'b01};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd23) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= 26'd0;
            root_reg <= 24'd0;
        end else if (busy_reg) begin
            rad_reg <= {rad_reg[45:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_reg  <= 26'(rem_sh - trial);
                root_reg <= {root_reg[22:0], 1'b1};
            end else begin
                rem_reg  <= rem_sh[25:0];
                root_reg <= {root_reg[22:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> src/ctilt_cell.sv
module ctilt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [4:0]        stage_idx,
    input  logic              in_vld,
    input  ctilt_pkg::cord_t  in_data,
    output logic              out_vld,
    output ctilt_pkg::cord_t  out_data
);
    import ctilt_pkg::*;

    logic  vld_reg;
    cord_t data_reg;
    cord_t data_next;
    logic signed [43:0] dx;
    logic signed [43:0] dy;

    // One vectoring micro-rotation
    always_comb begin
        dx = in_data.y >>> stage_idx;
        dy = in_data.x >>> stage_idx;
        data_next = in_data;
        if (!in_data.y[43]) begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + atan_tab(stage_idx);
        end else begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - atan_tab(stage_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign out_vld  = vld_reg;
    assign out_data = data_reg;

endmodule

>>> tb/sv/ctilt_checker.sv
`timescale 1ns / 100ps

module ctilt_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [ctilt_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [ctilt_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [ctilt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctilt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output int                                 fail_count,
    output int                                 pending_count
);
    import ctilt_pkg::*;

    typedef struct packed {
        logic [23:0] accel_pitch;
        logic [24:0] accel_roll;
        logic [27:0] pitch;
        logic [27:0] roll;
    } tilt_result_t;

    tilt_result_t expected_tilt_q[$];
    logic [15:0] step_scale;
    logic [16:0] blend_weight;
    longint roll_est, pitch_est;

    // Integer helpers, kept at 64 bits
    function automatic longint round_off(longint v, int sh);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (sh - 1))) >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    function automatic longint limit(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // Vectoring CORDIC, degrees with 24 fraction bits
    function automatic longint vector_angle(longint x, longint y);
        longint ofs, z, t, dx, dy;
        ofs = 0;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; ofs = 64'sd90 <<< 24;
            end else begin
                x = -y; y = t; ofs = -(64'sd90 <<< 24);
            end
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < 18; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += longint'(atan_tab(5'(i)));
            end else begin
                x -= dx; y += dy; z -= longint'(atan_tab(5'(i)));
            end
        end
        return ofs + z;
    endfunction

    function automatic longint mix_angle(longint est, longint rate, longint acc);
        longint w, pred;
        w = (blend_weight > 17'd65536) ? 65536 : longint'(blend_weight);
        pred = est + round_off(rate * longint'(step_scale), 8);
        return limit(round_off(w * pred + (65536 - w) * acc, 16), 64'sd1024 <<< 16);
    endfunction

    function automatic tilt_result_t predict_tilt(logic [79:0] d);
        longint ax, ay, az, gx, gy, mag, ar, ap;
        tilt_result_t r;
        ax = longint'($signed(d[15:0]));
        ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32]));
        gx = longint'($signed(d[63:48]));
        gy = longint'($signed(d[79:64]));
        mag = floor_sqrt(longint'(ay * ay + az * az) << 16);
        ar = limit(round_off(vector_angle(az, ay), 8), 64'sd180 <<< 16);
        ap = limit(round_off(vector_angle(mag, -ax * 256), 8), 64'sd90 <<< 16);
        roll_est = mix_angle(roll_est, gx, ar);
        pitch_est = mix_angle(pitch_est, gy, ap);
        r.roll = roll_est[27:0];
        r.pitch = pitch_est[27:0];
        r.accel_roll = ar[24:0];
        r.accel_pitch = ap[23:0];
        return r;
    endfunction

    assign pending_count = expected_tilt_q.size();

    always @(posedge aclk) begin
        tilt_result_t got, want;
        if (!aresetn) begin
            step_scale <= GYRO_STEP_SCALE_RST;
            blend_weight <= GYRO_WEIGHT_RST;
            roll_est = 0;
            pitch_est = 0;
            fail_count <= 0;
            expected_tilt_q.delete();
        end else begin
            if (cfg_wr_en && cfg_index == REG_GYRO_STEP_SCALE) step_scale <= cfg_wdata[15:0];
            if (cfg_wr_en && cfg_index == REG_GYRO_WEIGHT) blend_weight <= cfg_wdata;
            if (s_tvalid && s_tready) expected_tilt_q.push_back(predict_tilt(s_tdata));
            // result transaction compare
            if (m_tvalid && m_tready) begin
                got = m_tdata[104:0];
                if (expected_tilt_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result %h", got);
                end else begin
                    want = expected_tilt_q.pop_front();
                    if (got != want || m_tdata[111:105] != 0) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch roll %h/%h pitch %h/%h aroll %h/%h apitch %h/%h",
                                     want.roll, got.roll, want.pitch, got.pitch,
                                     want.accel_roll, got.accel_roll,
                                     want.accel_pitch, got.accel_pitch);
                    end
                end
            end
        end
    end
endmodule

>>> tb/sv/complementary_tilt_estimator_test.sv
`timescale 1ns / 100ps

module complementary_tilt_estimator_test;
    import ctilt_pkg::*;

    // Index past the last register, writes to it are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd5;

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tready, m_tvalid, m_tready = 0;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int fail_count, pending_count;
    int idle_cycles = 0;
    bit quiet_tail = 0, hold_off = 0;

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    complementary_tilt_estimator u_dut (.*);
    ctilt_checker u_chk (.*);

    // Watchdog on cycles with no transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off
    initial begin
        int n;
        @(posedge aresetn);
        forever begin
            if (hold_off) begin
                m_tready <= 0;
                repeat (600) @(posedge aclk);
                hold_off = 0;
            end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                m_tready <= 0;
                n = $urandom_range(1, 19);
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
        end
    end

    task automatic send_sample(logic [15:0] ax, ay, az, gx, gy);
        int n;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 0;
            n = $urandom_range(1, 19);
            repeat (n) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {gy, gx, az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        s_tvalid <= 0;
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 16)) - 8);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] corner[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        logic [15:0] scales[4] = '{16'd0, 16'hffff, 16'd5117, 16'd300};
        logic [16:0] weights[4] = '{17'd0, 17'd65536, 17'h1ffff, 17'd32768};
        repeat (5) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Directed: zero vector, axis extremes, all sign quadrants
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_sample(corner[(i + j) % 4], corner[i], corner[j],
                            corner[j], corner[i]);
        send_sample(16'h7fff, 16'h0000, 16'h0000, 16'h7fff, 16'h8000);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h7fff);
        drain();
        write_reg(REG_UNMAPPED, 17'h1ffff);

        // Random phases, each under its own register setting
        for (int p = 0; p < 6; p++) begin
            write_reg(REG_GYRO_STEP_SCALE, (p < 4) ? 17'(scales[p]) : 17'($urandom));
            write_reg(REG_GYRO_WEIGHT, (p < 4) ? weights[p] : 17'($urandom));
            if (p == 2) hold_off = 1;
            if (p == 5) quiet_tail = 1;
            for (int k = 0; k < 125; k++)
                send_sample(rand_axis(), rand_axis(), rand_axis(),
                            rand_axis(), rand_axis());
            drain();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> complementary_tilt_estimator.f
src/ctilt_pkg.sv
src/ctilt_sqrt.sv
src/ctilt_cell.sv
src/complementary_tilt_estimator.sv
tb/sv/ctilt_checker.sv
tb/sv/complementary_tilt_estimator_test.sv
